// ----- rtl/bap_pkg.sv -----
// ----------------------------------------------------------------------------
// bap_pkg: shared definitions for the allpass phaser
// Types, register indexes, widths and reset values used by the phaser top
// level and its shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bap_pkg;

   // Default size of the section bank.
   localparam int NUM_SECTIONS_DEF = 64;

   // Data widths.
   localparam int SAMPLE_W = 16;   // audio samples, Q1.15
   localparam int DATA_W   = 24;   // cascade values Q1.23, coefficients Q2.22
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = 60;   // holds every sum exactly (|sum| < 2^58)
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int COUNT_W    = 7;  // width of the sections_used register
   localparam int GAIN_W     = 16; // width of out_level and wet_mix

   // Fixed-point shifts.
   localparam int SEC_FRAC  = 22;  // Q3.45 sum back to Q1.23
   localparam int MIX_FRAC  = 37;  // scale 2^52 back to Q1.15
   localparam int HI_SHIFT  = 20;  // weight of the upper half of level*y
   localparam int DRY_SHIFT = 22;  // scale 2^30 of the dry term up to 2^52

   localparam logic signed [ACC_W-1:0] SEC_HALF = ACC_W'(1) << (SEC_FRAC - 1);
   localparam logic signed [ACC_W-1:0] MIX_HALF = ACC_W'(1) << (MIX_FRAC - 1);

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1       = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTIONS_USED = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LEVEL     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX       = 4'd7;

   // Register reset values.
   localparam logic [DATA_W-1:0]  RST_COEF_B0       = 24'd4194304;
   localparam logic [COUNT_W-1:0] RST_SECTIONS_USED = 7'd5;
   localparam logic [GAIN_W-1:0]  RST_OUT_LEVEL     = 16'd16384;
   localparam logic [GAIN_W-1:0]  RST_WET_MIX       = 16'd16384;

   // Last step of the section product sequence and of the mix sequence.
   localparam logic [2:0] MAC_LAST = 3'd4;
   localparam logic [2:0] MIX_LAST = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_ACC,
      ST_ROUND,
      ST_MIX,
      ST_MIX_ACC,
      ST_FINISH
   } state_type;

   // How the product issued in a cycle is folded into the accumulator.
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_ADD,
      ACC_SUB,
      ACC_ADD_HI,
      ACC_SUB_DRY
   } acc_mode_type;

   typedef struct packed {
      logic         clear;
      acc_mode_type mode;
   } mac_ctrl_type;

   // One history row per section.
   typedef struct packed {
      logic signed [DATA_W-1:0] in_1;
      logic signed [DATA_W-1:0] in_2;
      logic signed [DATA_W-1:0] out_1;
      logic signed [DATA_W-1:0] out_2;
   } hist_row_type;

endpackage

`default_nettype wire

// ----- rtl/bap_mac.sv -----
// ----------------------------------------------------------------------------
// bap_mac: shared multiply-accumulate unit
// One registered 24x24 signed multiplier followed by an accumulator that adds
// or subtracts the previous product, optionally shifted.
// ----------------------------------------------------------------------------
`default_nettype none

module bap_mac (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire bap_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [bap_pkg::DATA_W-1:0]   op_a,
   input  wire logic signed [bap_pkg::DATA_W-1:0]   op_b,
   output logic signed [bap_pkg::PROD_W-1:0]        prod,
   output logic signed [bap_pkg::ACC_W-1:0]         acc
);

   logic signed [bap_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [bap_pkg::ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   bap_pkg::acc_mode_type             pmode_ff;

   assign prod_in  = op_a * op_b;
   assign prod_ext = bap_pkg::ACC_W'(prod_ff);

   // The mode travels with its product so the add happens in the cycle after the multiply.
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else begin
         case (pmode_ff)
            bap_pkg::ACC_ADD:     acc_in = acc_ff + prod_ext;
            bap_pkg::ACC_SUB:     acc_in = acc_ff - prod_ext;
            bap_pkg::ACC_ADD_HI:  acc_in = acc_ff + (prod_ext <<< bap_pkg::HI_SHIFT);
            bap_pkg::ACC_SUB_DRY: acc_in = acc_ff - (prod_ext <<< bap_pkg::DRY_SHIFT);
            default:              acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmode_ff <= bap_pkg::ACC_NONE;
      end else begin
         pmode_ff <= ctrl.mode;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/biquad_allpass_phaser.sv -----
// ----------------------------------------------------------------------------
// biquad_allpass_phaser: phaser built from cascaded biquad allpass sections
// Passes each sample through the first sections_used sections of a bank that
// shares one coefficient set, then mixes the result with the dry sample.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload                          Transfer when
//   req_*     in          sample_in (16 bit signed Q1.15)  req_tvalid & req_tready
//   rsp_*     out         sample_out (16 bit signed Q1.15) rsp_tvalid & rsp_tready
//   csr_*     in          register index, write data       csr_valid & csr_ready
//
// The block takes a new sample only in its idle state, once the previous one is
// finished and its result loaded into the output register. The pace is set
// by the single shared 24x24 multiplier, which forms five products per section
// of the clamped section count and four for the mix.
// Reset is synchronous and active high; it restores the register defaults and
// clears one valid bit per history row, so unwritten rows read as zero.
// The finished sample sits in an output register; if it has not been taken
// when the next one is finished, the sequencer waits in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_allpass_phaser #(
   parameter int NUM_SECTIONS = bap_pkg::NUM_SECTIONS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   // Input stream.
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [15:0] req_tdata,   // [15:0] sample_in
   // Result stream.
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata,  // [15:0] sample_out
   // Configuration write channel.
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [bap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [bap_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int DATA_W  = bap_pkg::DATA_W;
   localparam int ACC_W   = bap_pkg::ACC_W;
   localparam int IDX_W   = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int LCNT_W  = $clog2(NUM_SECTIONS + 1);

   // ------------------------------------------------------------------
   // Configuration registers. The channel never stalls.
   // ------------------------------------------------------------------
   logic signed [DATA_W-1:0]          coef_b0_ff, coef_b1_ff, coef_b2_ff;
   logic signed [DATA_W-1:0]          coef_a1_ff, coef_a2_ff;
   logic [bap_pkg::COUNT_W-1:0]       sections_used_ff;
   logic [bap_pkg::GAIN_W-1:0]        out_level_ff, wet_mix_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff       <= bap_pkg::RST_COEF_B0;
         coef_b1_ff       <= '0;
         coef_b2_ff       <= '0;
         coef_a1_ff       <= '0;
         coef_a2_ff       <= '0;
         sections_used_ff <= bap_pkg::RST_SECTIONS_USED;
         out_level_ff     <= bap_pkg::RST_OUT_LEVEL;
         wet_mix_ff       <= bap_pkg::RST_WET_MIX;
      end else if (csr_valid && csr_ready) begin
         // Writes to an index past the register list are dropped.
         unique case (csr_index)
            bap_pkg::CSR_COEF_B0:       coef_b0_ff       <= csr_data;
            bap_pkg::CSR_COEF_B1:       coef_b1_ff       <= csr_data;
            bap_pkg::CSR_COEF_B2:       coef_b2_ff       <= csr_data;
            bap_pkg::CSR_COEF_A1:       coef_a1_ff       <= csr_data;
            bap_pkg::CSR_COEF_A2:       coef_a2_ff       <= csr_data;
            bap_pkg::CSR_SECTIONS_USED: sections_used_ff <= csr_data[bap_pkg::COUNT_W-1:0];
            bap_pkg::CSR_OUT_LEVEL:     out_level_ff     <= csr_data[bap_pkg::GAIN_W-1:0];
            bap_pkg::CSR_WET_MIX:       wet_mix_ff       <= csr_data[bap_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // A section count above the bank size is clamped to the bank size.
   logic [LCNT_W-1:0] n_eff;

   always_comb begin
      if (32'(sections_used_ff) > NUM_SECTIONS) begin
         n_eff = LCNT_W'(NUM_SECTIONS);
      end else begin
         n_eff = LCNT_W'(sections_used_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer state.
   // ------------------------------------------------------------------
   bap_pkg::state_type        state_ff, state_in;
   logic [2:0]                step_ff, step_in;
   logic [LCNT_W-1:0]         sec_ff, sec_in, n_ff, sec_next;
   logic                      in_xfer, out_free, out_load, last_sec;

   // Payload registers of the sample at work.
   logic signed [DATA_W-1:0]  x_ff;       // current section input, Q1.23
   logic signed [15:0]        xin_ff;     // dry sample
   logic signed [19:0]        hi_ff;      // upper half of level*y
   logic [15:0]               rsp_data_ff;
   logic                      rsp_valid_ff;

   assign in_xfer  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sec_next = sec_ff + 1'b1;
   assign last_sec = (sec_next == n_ff);

   // ------------------------------------------------------------------
   // Shared multiply-accumulate unit.
   // ------------------------------------------------------------------
   bap_pkg::mac_ctrl_type                 mac_ctrl;
   logic signed [DATA_W-1:0]              op_a, op_b;
   logic signed [bap_pkg::PROD_W-1:0]     mac_prod;
   logic signed [ACC_W-1:0]               mac_acc;

   bap_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   // ------------------------------------------------------------------
   // Section history memory. One row holds the four history words of a
   // section; a valid bit per row stands in for clearing the array.
   // ------------------------------------------------------------------
   bap_pkg::hist_row_type     hist_mem_ff [NUM_SECTIONS];
   bap_pkg::hist_row_type     rd_row_ff, cur_row, row_new;
   logic [NUM_SECTIONS-1:0]   row_vld_ff;
   logic                      rd_vld_ff, rd_en, wr_en;
   logic [IDX_W-1:0]          rd_addr, wr_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem_ff[wr_addr] <= row_new;
      end
      if (rd_en) begin
         rd_row_ff <= hist_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   // A row that was never written reads as zero history.
   assign cur_row = rd_vld_ff ? rd_row_ff : '0;

   // ------------------------------------------------------------------
   // Rounding of a section sum to Q1.23 and of the mix to Q1.15, both round
   // half up, then saturation.
   // ------------------------------------------------------------------
   logic signed [ACC_W-1:0]   sec_sum, sec_shift, mix_sum, mix_shift;
   logic signed [DATA_W-1:0]  sec_y;
   logic [15:0]               mix_y;

   always_comb begin
      sec_sum   = mac_acc + bap_pkg::SEC_HALF;
      sec_shift = sec_sum >>> bap_pkg::SEC_FRAC;
      if ((&sec_shift[ACC_W-1:DATA_W-1]) || !(|sec_shift[ACC_W-1:DATA_W-1])) begin
         sec_y = sec_shift[DATA_W-1:0];
      end else begin
         sec_y = sec_shift[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
      end

      mix_sum   = mac_acc + bap_pkg::MIX_HALF;
      mix_shift = mix_sum >>> bap_pkg::MIX_FRAC;
      if ((&mix_shift[ACC_W-1:15]) || !(|mix_shift[ACC_W-1:15])) begin
         mix_y = mix_shift[15:0];
      end else begin
         mix_y = mix_shift[ACC_W-1] ? 16'h8000 : 16'h7FFF;
      end
   end

   // New history row: the section input and output shift down one place.
   always_comb begin
      row_new.in_1  = x_ff;
      row_new.in_2  = cur_row.in_1;
      row_new.out_1 = sec_y;
      row_new.out_2 = cur_row.out_1;
   end

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bap_pkg::ST_IDLE: begin
            if (in_xfer) begin
               state_in = (n_eff == '0) ? bap_pkg::ST_MIX : bap_pkg::ST_READ;
            end
         end
         bap_pkg::ST_READ: begin
            state_in = bap_pkg::ST_MAC;
         end
         bap_pkg::ST_MAC: begin
            if (step_ff == bap_pkg::MAC_LAST) begin
               state_in = bap_pkg::ST_ACC;
            end
         end
         bap_pkg::ST_ACC: begin
            state_in = bap_pkg::ST_ROUND;
         end
         bap_pkg::ST_ROUND: begin
            state_in = last_sec ? bap_pkg::ST_MIX : bap_pkg::ST_MAC;
         end
         bap_pkg::ST_MIX: begin
            if (step_ff == bap_pkg::MIX_LAST) begin
               state_in = bap_pkg::ST_MIX_ACC;
            end
         end
         bap_pkg::ST_MIX_ACC: begin
            state_in = bap_pkg::ST_FINISH;
         end
         bap_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bap_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs of the sequencer: operand selection, unit control, memory
   // strobes and counters.
   // ------------------------------------------------------------------
   logic [16:0] wet_plus, wet_minus;

   // wet + 1.0 stays positive below 2^17; wet - 1.0 fits 17 bits signed.
   assign wet_plus  = {1'b0, wet_mix_ff} + 17'd32768;
   assign wet_minus = {1'b0, wet_mix_ff} - 17'd32768;

   always_comb begin
      op_a          = '0;
      op_b          = '0;
      mac_ctrl.clear = 1'b0;
      mac_ctrl.mode  = bap_pkg::ACC_NONE;
      rd_en         = 1'b0;
      rd_addr       = sec_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = sec_ff[IDX_W-1:0];
      step_in       = '0;
      sec_in        = sec_ff;
      req_tready    = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         bap_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            mac_ctrl.clear = 1'b1;
            sec_in         = '0;
         end
         bap_pkg::ST_READ: begin
            rd_en          = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         bap_pkg::ST_MAC: begin
            step_in = (step_ff == bap_pkg::MAC_LAST) ? 3'd0 : step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  op_a = coef_b0_ff;
                  op_b = x_ff;
                  mac_ctrl.mode = bap_pkg::ACC_ADD;
               end
               3'd1: begin
                  op_a = coef_b1_ff;
                  op_b = cur_row.in_1;
                  mac_ctrl.mode = bap_pkg::ACC_ADD;
               end
               3'd2: begin
                  op_a = coef_b2_ff;
                  op_b = cur_row.in_2;
                  mac_ctrl.mode = bap_pkg::ACC_ADD;
               end
               3'd3: begin
                  op_a = coef_a1_ff;
                  op_b = cur_row.out_1;
                  mac_ctrl.mode = bap_pkg::ACC_SUB;
               end
               default: begin
                  op_a = coef_a2_ff;
                  op_b = cur_row.out_2;
                  mac_ctrl.mode = bap_pkg::ACC_SUB;
               end
            endcase
         end
         bap_pkg::ST_ACC: begin
            // The last product lands in the accumulator.
         end
         bap_pkg::ST_ROUND: begin
            // Write back this section and, unless it is the last, fetch the next row in the same cycle.
            wr_en          = 1'b1;
            mac_ctrl.clear = 1'b1;
            if (!last_sec) begin
               rd_en   = 1'b1;
               rd_addr = sec_next[IDX_W-1:0];
               sec_in  = sec_next;
            end
         end
         bap_pkg::ST_MIX: begin
            step_in = (step_ff == bap_pkg::MIX_LAST) ? 3'd0 : step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  // level * y, kept whole and split below
                  op_a = x_ff;
                  op_b = $signed({8'b0, out_level_ff});
               end
               3'd1: begin
                  op_a = $signed({4'b0, mac_prod[19:0]});
                  op_b = $signed({7'b0, wet_plus});
                  mac_ctrl.mode = bap_pkg::ACC_ADD;
               end
               3'd2: begin
                  op_a = {{4{hi_ff[19]}}, hi_ff};
                  op_b = $signed({7'b0, wet_plus});
                  mac_ctrl.mode = bap_pkg::ACC_ADD_HI;
               end
               default: begin
                  op_a = {{8{xin_ff[15]}}, xin_ff};
                  op_b = {{7{wet_minus[16]}}, wet_minus};
                  mac_ctrl.mode = bap_pkg::ACC_SUB_DRY;
               end
            endcase
         end
         bap_pkg::ST_MIX_ACC: begin
            // The dry product lands in the accumulator.
         end
         bap_pkg::ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bap_pkg::ST_IDLE;
         step_ff      <= '0;
         sec_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sec_ff   <= sec_in;
         if (in_xfer) begin
            n_ff <= n_eff;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         xin_ff <= req_tdata;
         x_ff   <= {req_tdata, 8'b0};
      end else if (state_ff == bap_pkg::ST_ROUND) begin
         // The section output becomes the next section's input.
         x_ff <= sec_y;
      end
      if (state_ff == bap_pkg::ST_MIX && step_ff == 3'd1) begin
         hi_ff <= mac_prod[39:20];
      end
      if (out_load) begin
         rsp_data_ff <= mix_y;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // A transfer starts a sample, so the block is busy in the next cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      in_xfer |=> !req_tready)
      else $error("input ready right after a transfer");

   // A finished sample is only loaded into a free output register.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten");

   // Products are only formed for sections inside the cascade.
   a_sec_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bap_pkg::ST_MAC) |-> (sec_ff < n_ff))
      else $error("section index past the cascade length");

   // Row writes happen only in the write-back step, which follows the accumulate step.
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bap_pkg::ST_ROUND) && $past(state_ff == bap_pkg::ST_ACC))
      else $error("history write outside the write-back step");

endmodule

`default_nettype wire

// ----- tb/tb_biquad_allpass_phaser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_allpass_phaser: self-checking bench for the allpass phaser
// Drives audio samples through the input stream and programs the coefficient
// and mix registers. It predicts every output sample with its own model of the
// section cascade and the wet/dry mix, and checks each result transfer in
// order under varied idling, stalling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_biquad_allpass_phaser;

   localparam int BANK_SIZE   = bap_pkg::NUM_SECTIONS_DEF;
   localparam int DATA_W      = bap_pkg::DATA_W;
   localparam int COUNT_W     = bap_pkg::COUNT_W;
   localparam int GAIN_W      = bap_pkg::GAIN_W;
   localparam int CSR_IDX_W   = bap_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = bap_pkg::CSR_DATA_W;
   // This limit leaves ample margin over the slowest legal run.
   localparam int CYCLE_LIMIT = 4_000_000;
   // One full-bank sample plus some slack, waited out after the last result.
   localparam int DRAIN_TAIL  = 7 * BANK_SIZE + 8 + 40;
   localparam int MAX_REPORTS = 10;
   localparam int CONFIG_RUN  = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = bap_pkg::CSR_WET_MIX + 1'b1;
   localparam logic signed [DATA_W-1:0] Q22_ONE  = 24'sd4194304;
   localparam logic signed [DATA_W-1:0] COEF_MAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] COEF_MIN = 24'sh800000;

   // Register image kept by the bench, updated at each accepted write.
   typedef struct {
      logic signed [DATA_W-1:0] b0;
      logic signed [DATA_W-1:0] b1;
      logic signed [DATA_W-1:0] b2;
      logic signed [DATA_W-1:0] a1;
      logic signed [DATA_W-1:0] a2;
      logic [COUNT_W-1:0]       sections;
      logic [GAIN_W-1:0]        level;
      logic [GAIN_W-1:0]        wet;
   } phaser_cfg_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [15:0]           req_tdata  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [15:0]           rsp_tdata;
   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Predictor state: registers and the per-section histories.
   phaser_cfg_type           cfg;
   logic signed [DATA_W-1:0] sec_in_1  [BANK_SIZE];
   logic signed [DATA_W-1:0] sec_in_2  [BANK_SIZE];
   logic signed [DATA_W-1:0] sec_out_1 [BANK_SIZE];
   logic signed [DATA_W-1:0] sec_out_2 [BANK_SIZE];

   // Output samples predicted but not yet seen, oldest first.
   logic [15:0] expected_samples [$];
   logic [15:0] want_sample;

   int send_idle_pct;
   int rsp_stall_pct;
   // A hold-off is requested by bumping the sequence number; the receiver
   // process then counts the requested length down on its own.
   int rsp_hold_len    = 0;
   int rsp_hold_seq    = 0;
   int hold_left       = 0;
   int hold_seq_seen   = 0;
   int mismatch_count  = 0;
   int samples_checked = 0;
   int samples_sent;
   int csr_writes;
   int cycle_count;

   biquad_allpass_phaser #(
      .NUM_SECTIONS(BANK_SIZE)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] sample_out
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Round half up by adding half an LSB and flooring, then clamp.
   function automatic longint round_sat(input longint v, input int sh,
                                        input longint lo, input longint hi);
      longint r;
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r < lo) begin
         r = lo;
      end else if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // Runs one sample through the active sections, updating their histories,
   // and returns the mixed and saturated output sample.
   function automatic logic [15:0] mix_cascade_sample(input logic signed [15:0] s);
      longint dry;
      longint x;
      longint acc;
      longint lvl;
      longint wet;
      int     n;
      int     i;
      dry = s;
      x   = dry * 256;
      n   = cfg.sections;
      if (n > BANK_SIZE) begin
         n = BANK_SIZE;
      end
      for (i = 0; i < n; i++) begin
         acc = longint'(cfg.b0) * x
             + longint'(cfg.b1) * longint'(sec_in_1[i])
             + longint'(cfg.b2) * longint'(sec_in_2[i])
             - longint'(cfg.a1) * longint'(sec_out_1[i])
             - longint'(cfg.a2) * longint'(sec_out_2[i]);
         acc = round_sat(acc, bap_pkg::SEC_FRAC, -(longint'(1) <<< 23),
                         (longint'(1) <<< 23) - 1);
         sec_in_2[i]  = sec_in_1[i];
         sec_in_1[i]  = x[DATA_W-1:0];
         sec_out_2[i] = sec_out_1[i];
         sec_out_1[i] = acc[DATA_W-1:0];
         x = acc;
      end
      lvl = cfg.level;
      wet = cfg.wet;
      // Wet path at scale 2^52, dry path lifted from 2^30 to the same scale.
      acc = lvl * x * (wet + 32768)
          - dry * (wet - 32768) * (longint'(1) <<< bap_pkg::DRY_SHIFT);
      return 16'(round_sat(acc, bap_pkg::MIX_FRAC, -32768, 32767));
   endfunction

   // One register write transfer. The caller lowers csr_valid after the burst,
   // so back-to-back writes keep the valid high without a glitch.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bap_pkg::CSR_COEF_B0:       cfg.b0       = value;
         bap_pkg::CSR_COEF_B1:       cfg.b1       = value;
         bap_pkg::CSR_COEF_B2:       cfg.b2       = value;
         bap_pkg::CSR_COEF_A1:       cfg.a1       = value;
         bap_pkg::CSR_COEF_A2:       cfg.a2       = value;
         bap_pkg::CSR_SECTIONS_USED: cfg.sections = value[COUNT_W-1:0];
         bap_pkg::CSR_OUT_LEVEL:     cfg.level    = value[GAIN_W-1:0];
         bap_pkg::CSR_WET_MIX:       cfg.wet      = value[GAIN_W-1:0];
         default: ;  // Indexes past the last register are dropped by the block.
      endcase
      csr_writes++;
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] b0, input logic [CSR_DATA_W-1:0] b1,
                              input logic [CSR_DATA_W-1:0] b2, input logic [CSR_DATA_W-1:0] a1,
                              input logic [CSR_DATA_W-1:0] a2, input logic [CSR_DATA_W-1:0] sec,
                              input logic [CSR_DATA_W-1:0] lvl, input logic [CSR_DATA_W-1:0] wet);
      write_reg(bap_pkg::CSR_COEF_B0, b0);
      write_reg(bap_pkg::CSR_COEF_B1, b1);
      write_reg(bap_pkg::CSR_COEF_B2, b2);
      write_reg(bap_pkg::CSR_COEF_A1, a1);
      write_reg(bap_pkg::CSR_COEF_A2, a2);
      write_reg(bap_pkg::CSR_SECTIONS_USED, sec);
      write_reg(bap_pkg::CSR_OUT_LEVEL, lvl);
      write_reg(bap_pkg::CSR_WET_MIX, wet);
      csr_valid <= 1'b0;
   endtask

   // Picks a coefficient set: mostly a proper allpass (b0 = a2, b1 = a1,
   // b2 = 1), sometimes raw full-range values. Upper data bits above each
   // register's width are filled with noise, which the block must mask off.
   task automatic randomize_config(input int sec_lo, input int sec_hi);
      logic signed [DATA_W-1:0] pole_1;
      logic signed [DATA_W-1:0] pole_2;
      logic [CSR_DATA_W-1:0]    sec_word;
      logic [CSR_DATA_W-1:0]    lvl_word;
      logic [CSR_DATA_W-1:0]    wet_word;
      pole_2   = 24'($urandom_range(0, 3774873));
      pole_1   = 24'($urandom_range(0, 8388608) - 4194304);
      sec_word = {17'($urandom), 7'($urandom_range(sec_lo, sec_hi))};
      lvl_word = {8'($urandom), 16'($urandom_range(8192, 24576))};
      wet_word = {8'($urandom), 16'($urandom_range(0, 32768))};
      case ($urandom_range(7))
         0: lvl_word[15:0] = 16'd0;
         1: lvl_word[15:0] = 16'hFFFF;
         2: lvl_word[15:0] = 16'($urandom);
         default: ;
      endcase
      case ($urandom_range(7))
         0: wet_word[15:0] = 16'd0;
         1: wet_word[15:0] = 16'd32768;
         2: wet_word[15:0] = 16'hFFFF;
         3: wet_word[15:0] = 16'($urandom);
         default: ;
      endcase
      if ($urandom_range(3) == 0) begin
         load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), sec_word, lvl_word, wet_word);
      end else begin
         load_config(pole_2, pole_1, Q22_ONE, pole_1, pole_2, sec_word, lvl_word, wet_word);
      end
   endtask

   // Offers one sample until its transfer, then records the predicted output.
   // With the idle chance set, the valid drops for a random gap afterwards.
   task automatic send_sample(input logic [15:0] s);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(mix_cascade_sample(s));
      samples_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 48)) @(posedge clock);
      end
   endtask

   // Stops offering samples and waits until every predicted output has come.
   task automatic wait_idle();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
      end
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   // Result side: a long hold-off when one is requested, otherwise random
   // stalls at the current rate.
   always @(posedge clock) begin
      if (rsp_hold_seq != hold_seq_seen) begin
         hold_seq_seen = rsp_hold_seq;
         hold_left     = rsp_hold_len;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            if (mismatch_count < MAX_REPORTS) begin
               $display("Result transfer with none expected: sample_out=%0d",
                        $signed(rsp_tdata));
            end
            mismatch_count++;
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_tdata !== want_sample) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("Mismatch on result %0d: sample_out expected %0d, got %0d",
                           samples_checked, $signed(want_sample), $signed(rsp_tdata));
               end
               mismatch_count++;
            end
            samples_checked++;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run timed out after %0d cycles", cycle_count);
      $display("** biquad_allpass_phaser: FAILED **");
      $finish;
   end

   // Defaults after reset: unity b0 over five sections, unity level, half mix.
   task automatic test_reset_defaults();
      send_sample(16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      wait_idle();
   endtask

   // Extreme coefficients over the full bank drive every section into
   // saturation; maximum level and a mix above one push the output limits.
   task automatic test_extreme_coefficients();
      load_config(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
                  24'(BANK_SIZE), 24'hFFFFFF, 24'h00FFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      wait_idle();
   endtask

   // Writes past the last register must leave the configuration alone.
   task automatic test_unknown_registers();
      logic [CSR_IDX_W-1:0] idx;
      idx = CSR_FIRST_UNUSED;
      do begin
         write_reg(idx, 24'($urandom));
         idx++;
      end while (idx != '0);
      csr_valid <= 1'b0;
      send_sample(16'h4000);
      send_sample(16'hC000);
      wait_idle();
   endtask

   // Shrinking the cascade leaves the histories of the idle sections as they
   // were; growing it again must pick those histories up unchanged.
   task automatic test_partial_cascade();
      write_reg(bap_pkg::CSR_SECTIONS_USED, 24'd2);
      csr_valid <= 1'b0;
      send_sample(16'h1234);
      send_sample(16'hEDCC);
      wait_idle();
      write_reg(bap_pkg::CSR_SECTIONS_USED, 24'(BANK_SIZE));
      csr_valid <= 1'b0;
      send_sample(16'h2000);
      send_sample(16'hE000);
      wait_idle();
   endtask

   // An all-ones count masks to 127 sections, which clamps to the bank size.
   task automatic test_section_clamp();
      load_config(24'd1887436, 24'hE00000, Q22_ONE, 24'hE00000, 24'd1887436,
                  24'hFFFFFF, 24'd16384, 24'd16384);
      send_sample(16'h6000);
      send_sample(16'h9000);
      send_sample(16'h0100);
      wait_idle();
   endtask

   // With no sections the cascade hands the input straight to the mix.
   // Level and mix at zero give the dry sample; then a full-wet setting.
   task automatic test_no_sections();
      load_config(Q22_ONE, 24'd0, 24'd0, 24'd0, 24'd0, {17'h1FFFF, 7'd0}, 24'd0, 24'd0);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0ABC);
      wait_idle();
      write_reg(bap_pkg::CSR_OUT_LEVEL, 24'd16384);
      write_reg(bap_pkg::CSR_WET_MIX, 24'd32768);
      csr_valid <= 1'b0;
      send_sample(16'h3FFF);
      send_sample(16'hC001);
      wait_idle();
   endtask

   // Random samples over short cascades, with a fresh configuration every
   // CONFIG_RUN samples, each applied only once the block has drained.
   task automatic run_random_phase(input int send_pct, input int stall_pct, input int count);
      logic [15:0] s;
      int          k;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (k = 0; k < count; k++) begin
         if (k % CONFIG_RUN == 0) begin
            wait_idle();
            randomize_config(0, ($urandom_range(4) == 0) ? 16 : 8);
         end
         case ($urandom_range(9))
            0:       s = 16'h7FFF;
            1:       s = 16'h8000;
            2, 3:    s = 16'($urandom_range(0, 1023) - 512);
            default: s = 16'($urandom);
         endcase
         send_sample(s);
      end
      wait_idle();
   endtask

   // Two runs over the whole bank, one of them with counts above it.
   task automatic test_full_bank();
      int k;
      int r;
      send_idle_pct = 30;
      rsp_stall_pct = 30;
      for (r = 0; r < 2; r++) begin
         wait_idle();
         randomize_config(r == 0 ? BANK_SIZE : BANK_SIZE + 1, r == 0 ? BANK_SIZE : 127);
         for (k = 0; k < 30; k++) begin
            send_sample(16'($urandom));
         end
      end
      wait_idle();
   endtask

   // The result side holds off for a long stretch while samples keep coming,
   // so the output register fills and the input stalls. Then the sender
   // pauses until every expected result has come before a final burst.
   task automatic test_backpressure();
      int k;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      randomize_config(2, 6);
      rsp_hold_len = 1200;
      rsp_hold_seq++;
      for (k = 0; k < 16; k++) begin
         send_sample(16'($urandom));
      end
      wait_idle();
      for (k = 0; k < 4; k++) begin
         send_sample(16'($urandom));
      end
      wait_idle();
   endtask

   initial begin : main
      int i;
      cfg.b0       = bap_pkg::RST_COEF_B0;
      cfg.b1       = '0;
      cfg.b2       = '0;
      cfg.a1       = '0;
      cfg.a2       = '0;
      cfg.sections = bap_pkg::RST_SECTIONS_USED;
      cfg.level    = bap_pkg::RST_OUT_LEVEL;
      cfg.wet      = bap_pkg::RST_WET_MIX;
      for (i = 0; i < BANK_SIZE; i++) begin
         sec_in_1[i]  = '0;
         sec_in_2[i]  = '0;
         sec_out_1[i] = '0;
         sec_out_2[i] = '0;
      end
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      samples_sent    = 0;
      csr_writes      = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extreme_coefficients();
      test_unknown_registers();
      test_partial_cascade();
      test_section_clamp();
      test_no_sections();
      run_random_phase(0, 0, 350);
      run_random_phase(59, 0, 350);
      run_random_phase(0, 59, 350);
      run_random_phase(30, 30, 350);
      test_full_bank();
      test_backpressure();

      // Everything has drained; give the block time to show any stray result.
      wait_idle();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Sent %0d samples and %0d register writes: defaults, extremes, clamp, bypass,",
               samples_sent, csr_writes);
      $display("four idle/stall mixes, full bank and a long hold-off; %0d checked, %0d bad.",
               samples_checked, mismatch_count);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("** biquad_allpass_phaser: PASSED **");
      end else begin
         $display("** biquad_allpass_phaser: FAILED **");
      end
      $finish;
   end

endmodule

// ----- biquad_allpass_phaser.f -----
rtl/bap_pkg.sv
rtl/bap_mac.sv
rtl/biquad_allpass_phaser.sv
tb/tb_biquad_allpass_phaser.sv
